### hdl/gali_pkg.sv
// shared constants, types and control structs for the curve interpolator
`default_nettype none

package gali_pkg;

	// curve table size
	localparam int CURVE_POINTS = 16384;
	localparam int IDX_W        = $clog2(CURVE_POINTS);
	localparam int CNT_W        = $clog2(CURVE_POINTS + 1);

	// field widths
	localparam int POS_W      = 16;
	localparam int VAL_W      = 16;
	localparam int FRAC_W     = 8;
	localparam int RES_W      = VAL_W + FRAC_W;
	localparam int GAP_W      = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// arithmetic widths
	localparam int SPAN2_W    = POS_W + 1;
	localparam int ACC_W      = VAL_W + POS_W;
	localparam int DIVIDEND_W = ACC_W + FRAC_W + 2;
	localparam int DIV_CNT_W  = $clog2(RES_W);

	localparam logic [GAP_W-1:0] MAX_GAP_RESET = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_GAP   = 0,
		REG_HOLD_ENDS = 1
	} cfg_reg_t;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} item_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLASS,
		ST_BS,
		ST_BS_CMP,
		ST_L_RD,
		ST_L_CMP,
		ST_R_RD,
		ST_R_CMP,
		ST_GAP,
		ST_MUL1,
		ST_MUL2,
		ST_DIV_INIT,
		ST_DIV,
		ST_EMIT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		RES_MISSING,
		RES_FIRST,
		RES_LAST,
		RES_QUOT
	} res_sel_t;

	typedef enum logic [1:0] {
		RD_MID,
		RD_LEFT,
		RD_RIGHT
	} rd_sel_t;

	typedef struct packed {
		logic    known;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
	} curve_entry_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     latch_q;
		logic     bs_init;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     bs_step;
		logic     l_take;
		logic     l_dec;
		logic     r_take;
		logic     r_inc;
		logic     gap;
		logic     mul1;
		logic     mul2;
		logic     div_init;
		logic     div_step;
		logic     emit;
		res_sel_t res_sel;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cnt_zero;
		logic below_first;
		logic above_last;
		logic at_last;
		logic hold_ends;
		logic bs_done;
		logic rd_known;
		logic l_at_first;
		logic r_at_last;
		logic gap_ok;
		logic div_last;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

### hdl/gali_if.sv
// request channel interfaces: input items, results and register writes
`default_nettype none

interface gali_item_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic                       first_point;
	logic [gali_pkg::POS_W-1:0] position;
	logic [gali_pkg::VAL_W-1:0] point_value;
	logic                       value_known;

	modport source (
		output valid, kind, first_point, position, point_value, value_known,
		input  ready
	);
	modport sink (
		input  valid, kind, first_point, position, point_value, value_known,
		output ready
	);
endinterface

interface gali_result_if;
	logic                       valid;
	logic                       ready;
	logic [gali_pkg::RES_W-1:0] result_value;
	logic                       result_known;

	modport source (
		output valid, result_value, result_known,
		input  ready
	);
	modport sink (
		input  valid, result_value, result_known,
		output ready
	);
endinterface

interface gali_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [gali_pkg::CFG_IDX_W-1:0]  index;
	logic [gali_pkg::CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

`default_nettype wire

### hdl/gali_ctrl.sv
// controller state machine sequencing loads and queries
`default_nettype none

module gali_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_kind,
	output logic                      in_ready,
	output gali_pkg::dp_cmd_t         cmd,
	input  wire gali_pkg::dp_status_t status
);

	gali_pkg::ctrl_state_t state_q, state_d;
	gali_pkg::res_sel_t    res_sel_q, res_sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= gali_pkg::ST_IDLE;
			res_sel_q <= gali_pkg::RES_MISSING;
		end else begin
			state_q   <= state_d;
			res_sel_q <= res_sel_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		res_sel_d   = res_sel_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.rd_sel  = gali_pkg::RD_MID;
		cmd.res_sel = res_sel_q;
		case (state_q)
			gali_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_kind == gali_pkg::KIND_QUERY) begin
						cmd.latch_q = 1'b1;
						state_d     = gali_pkg::ST_CLASS;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			gali_pkg::ST_CLASS: begin
				if (status.cnt_zero) begin
					res_sel_d = gali_pkg::RES_MISSING;
					state_d   = gali_pkg::ST_EMIT;
				end else if (status.below_first) begin
					res_sel_d = status.hold_ends ? gali_pkg::RES_FIRST : gali_pkg::RES_MISSING;
					state_d   = gali_pkg::ST_EMIT;
				end else if (status.above_last) begin
					res_sel_d = (status.hold_ends || status.at_last) ?
						gali_pkg::RES_LAST : gali_pkg::RES_MISSING;
					state_d   = gali_pkg::ST_EMIT;
				end else begin
					cmd.bs_init = 1'b1;
					state_d     = gali_pkg::ST_BS;
				end
			end
			gali_pkg::ST_BS: begin
				if (status.bs_done) begin
					state_d = gali_pkg::ST_L_RD;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = gali_pkg::RD_MID;
					state_d    = gali_pkg::ST_BS_CMP;
				end
			end
			gali_pkg::ST_BS_CMP: begin
				cmd.bs_step = 1'b1;
				state_d     = gali_pkg::ST_BS;
			end
			gali_pkg::ST_L_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = gali_pkg::RD_LEFT;
				state_d    = gali_pkg::ST_L_CMP;
			end
			gali_pkg::ST_L_CMP: begin
				if (status.rd_known || status.l_at_first) begin
					cmd.l_take = 1'b1;
					state_d    = gali_pkg::ST_R_RD;
				end else begin
					cmd.l_dec = 1'b1;
					state_d   = gali_pkg::ST_L_RD;
				end
			end
			gali_pkg::ST_R_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = gali_pkg::RD_RIGHT;
				state_d    = gali_pkg::ST_R_CMP;
			end
			gali_pkg::ST_R_CMP: begin
				if (status.rd_known || status.r_at_last) begin
					cmd.r_take = 1'b1;
					state_d    = gali_pkg::ST_GAP;
				end else begin
					cmd.r_inc = 1'b1;
					state_d   = gali_pkg::ST_R_RD;
				end
			end
			gali_pkg::ST_GAP: begin
				cmd.gap = 1'b1;
				if (status.gap_ok) begin
					state_d = gali_pkg::ST_MUL1;
				end else begin
					res_sel_d = gali_pkg::RES_MISSING;
					state_d   = gali_pkg::ST_EMIT;
				end
			end
			gali_pkg::ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = gali_pkg::ST_MUL2;
			end
			gali_pkg::ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = gali_pkg::ST_DIV_INIT;
			end
			gali_pkg::ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = gali_pkg::ST_DIV;
			end
			gali_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					res_sel_d = gali_pkg::RES_QUOT;
					state_d   = gali_pkg::ST_EMIT;
				end
			end
			gali_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = gali_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gali_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### hdl/gali_dp.sv
// datapath: curve table memory, search registers, multiplier, divider, result register
`default_nettype none

module gali_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire gali_pkg::dp_cmd_t               cmd,
	output gali_pkg::dp_status_t                 status,
	input  wire logic                            in_first_point,
	input  wire logic [gali_pkg::POS_W-1:0]      in_position,
	input  wire logic [gali_pkg::VAL_W-1:0]      in_point_value,
	input  wire logic                            in_value_known,
	input  wire logic                            cfg_valid,
	input  wire logic [gali_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gali_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            out_ready,
	output logic                                 out_valid,
	output logic [gali_pkg::RES_W-1:0]           out_value,
	output logic                                 out_known
);

	localparam int IDX_W      = gali_pkg::IDX_W;
	localparam int CNT_W      = gali_pkg::CNT_W;
	localparam int POS_W      = gali_pkg::POS_W;
	localparam int VAL_W      = gali_pkg::VAL_W;
	localparam int RES_W      = gali_pkg::RES_W;
	localparam int FRAC_W     = gali_pkg::FRAC_W;
	localparam int ACC_W      = gali_pkg::ACC_W;
	localparam int SPAN2_W    = gali_pkg::SPAN2_W;
	localparam int DIVIDEND_W = gali_pkg::DIVIDEND_W;
	localparam int DIV_CNT_W  = gali_pkg::DIV_CNT_W;

	// curve table
	gali_pkg::curve_entry_t mem_q [gali_pkg::CURVE_POINTS];
	gali_pkg::curve_entry_t rd_q;
	gali_pkg::curve_entry_t wr_entry;
	logic [IDX_W-1:0]       wr_addr;
	logic [IDX_W-1:0]       rd_addr;
	logic                   wr_en;
	logic                   load_ok;

	// table bookkeeping
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       last_idx;
	logic [POS_W-1:0]       first_pos_q, last_pos_q;
	logic [VAL_W-1:0]       first_val_q, last_val_q;
	logic                   first_known_q, last_known_q;

	// registers
	logic [gali_pkg::GAP_W-1:0] max_gap_q;
	logic                       hold_ends_q;

	// search
	logic [POS_W-1:0]       q_q;
	logic [IDX_W-1:0]       lo_q, hi_q;
	logic [IDX_W:0]         mid_sum;
	logic [IDX_W-1:0]       mid_idx;
	logic [IDX_W-1:0]       bs_width;
	logic [POS_W-1:0]       lpos_q, rpos_q;
	logic [VAL_W-1:0]       lval_q, rval_q;
	logic                   lknown_q, rknown_q;

	// interpolation
	logic [POS_W-1:0]       span_w, span_m1;
	logic [POS_W-1:0]       span_q, d_q, wl;
	logic [ACC_W-1:0]       prod_l, prod_r, acc_q;
	logic [DIVIDEND_W-1:0]  dividend;
	logic [SPAN2_W-1:0]     divisor;
	logic [SPAN2_W-1:0]     rem_q;
	logic [SPAN2_W:0]       trial, diff;
	logic                   ge;
	logic [RES_W-1:0]       quo_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;

	// result register
	logic                   out_vld_q;
	logic [RES_W-1:0]       out_value_q;
	logic                   out_known_q;

	// ---------------- loads ----------------
	assign last_idx = cnt_q - CNT_W'(1);
	assign load_ok  = in_first_point ||
		((cnt_q < CNT_W'(gali_pkg::CURVE_POINTS)) &&
		 ((cnt_q == '0) || (in_position > last_pos_q)));
	assign wr_en    = cmd.load && load_ok;
	assign wr_addr  = in_first_point ? '0 : cnt_q[IDX_W-1:0];
	assign wr_entry = '{known: in_value_known, pos: in_position, val: in_point_value};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (wr_en) begin
			cnt_q <= in_first_point ? CNT_W'(1) : cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			last_pos_q   <= in_position;
			last_val_q   <= in_point_value;
			last_known_q <= in_value_known;
			if (in_first_point || (cnt_q == '0)) begin
				first_pos_q   <= in_position;
				first_val_q   <= in_point_value;
				first_known_q <= in_value_known;
			end
		end
	end

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q   <= gali_pkg::MAX_GAP_RESET;
			hold_ends_q <= 1'b0;
		end else if (cfg_valid) begin
			case (gali_pkg::cfg_reg_t'(cfg_index))
				gali_pkg::REG_MAX_GAP:   max_gap_q   <= cfg_data;
				gali_pkg::REG_HOLD_ENDS: hold_ends_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------- search ----------------
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_idx  = mid_sum[IDX_W:1];
	assign bs_width = hi_q - lo_q;

	always_comb begin
		case (cmd.rd_sel)
			gali_pkg::RD_MID:   rd_addr = mid_idx;
			gali_pkg::RD_LEFT:  rd_addr = lo_q;
			gali_pkg::RD_RIGHT: rd_addr = hi_q;
			default:            rd_addr = mid_idx;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_q) begin
			q_q <= in_position;
		end
		if (cmd.bs_init) begin
			lo_q <= '0;
			hi_q <= last_idx[IDX_W-1:0];
		end else if (cmd.bs_step) begin
			if (rd_q.pos <= q_q) begin
				lo_q <= mid_idx;
			end else begin
				hi_q <= mid_idx;
			end
		end else begin
			if (cmd.l_dec) begin
				lo_q <= lo_q - IDX_W'(1);
			end
			if (cmd.r_inc) begin
				hi_q <= hi_q + IDX_W'(1);
			end
		end
		if (cmd.l_take) begin
			lpos_q   <= rd_q.pos;
			lval_q   <= rd_q.val;
			lknown_q <= rd_q.known;
		end
		if (cmd.r_take) begin
			rpos_q   <= rd_q.pos;
			rval_q   <= rd_q.val;
			rknown_q <= rd_q.known;
		end
	end

	// ---------------- interpolation ----------------
	assign span_w  = rpos_q - lpos_q;
	assign span_m1 = span_w - POS_W'(1);
	assign wl      = span_q - d_q;
	assign prod_l  = ACC_W'(lval_q) * ACC_W'(wl);
	assign prod_r  = ACC_W'(rval_q) * ACC_W'(d_q);

	// rounded quotient: (2*num + span) / (2*span), num = acc << FRAC_W
	assign dividend = DIVIDEND_W'({acc_q, {(FRAC_W + 1){1'b0}}}) + DIVIDEND_W'(span_q);
	assign divisor  = {span_q, 1'b0};
	assign trial    = {rem_q, quo_q[RES_W-1]};
	assign ge       = trial >= {1'b0, divisor};
	assign diff     = trial - {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (cmd.gap) begin
			span_q <= span_w;
			d_q    <= q_q - lpos_q;
		end
		if (cmd.mul1) begin
			acc_q <= prod_l;
		end else if (cmd.mul2) begin
			acc_q <= acc_q + prod_r;
		end
		if (cmd.div_init) begin
			// quotient fits the result width, so the upper part is below the divisor
			rem_q     <= dividend[RES_W +: SPAN2_W];
			quo_q     <= dividend[RES_W-1:0];
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= ge ? diff[SPAN2_W-1:0] : trial[SPAN2_W-1:0];
			quo_q     <= {quo_q[RES_W-2:0], ge};
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.res_sel)
				gali_pkg::RES_MISSING: begin
					out_value_q <= '0;
					out_known_q <= 1'b0;
				end
				gali_pkg::RES_FIRST: begin
					out_value_q <= first_known_q ? {first_val_q, {FRAC_W{1'b0}}} : '0;
					out_known_q <= first_known_q;
				end
				gali_pkg::RES_LAST: begin
					out_value_q <= last_known_q ? {last_val_q, {FRAC_W{1'b0}}} : '0;
					out_known_q <= last_known_q;
				end
				gali_pkg::RES_QUOT: begin
					out_value_q <= quo_q;
					out_known_q <= 1'b1;
				end
				default: begin
					out_value_q <= '0;
					out_known_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid = out_vld_q;
	assign out_value = out_value_q;
	assign out_known = out_known_q;

	// ---------------- status ----------------
	always_comb begin
		status             = '0;
		status.cnt_zero    = (cnt_q == '0);
		status.below_first = (q_q < first_pos_q);
		status.above_last  = (q_q >= last_pos_q);
		status.at_last     = (q_q == last_pos_q);
		status.hold_ends   = hold_ends_q;
		status.bs_done     = (bs_width == IDX_W'(1));
		status.rd_known    = rd_q.known;
		status.l_at_first  = (lo_q == '0);
		status.r_at_last   = (hi_q == last_idx[IDX_W-1:0]);
		status.gap_ok      = lknown_q && rknown_q && (span_m1 <= max_gap_q);
		status.div_last    = (div_cnt_q == DIV_CNT_W'(RES_W - 1));
		status.out_free    = !out_vld_q || out_ready;
	end

	// ---------------- assertions ----------------
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(gali_pkg::CURVE_POINTS))
		else $error("point count beyond table size");

	a_bs_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bs_step |-> (lo_q < hi_q))
		else $error("search bounds crossed");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < divisor))
		else $error("divider remainder not below divisor");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_vld_q || out_ready))
		else $error("result overwritten while pending");

	a_missing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_known_q) |-> (out_value_q == '0))
		else $error("missing result with nonzero value");

endmodule

`default_nettype wire

### hdl/gap_aware_linear_interpolator.sv
// top level of the gap-aware piecewise linear curve interpolator
//
// Holds a curve table of up to gali_pkg::CURVE_POINTS points (position, value,
// known bit) in a memory with one write and one read port and answers queries
// with an unsigned Q16.8 value rounded to nearest, ties up. A load with
// first_point restarts the table, and loads past capacity or with a position not
// above the last stored one are dropped. A query is latched and then classified
// against the cached first and last points; a query outside the curve (or at the
// last position, or on an empty table) then goes straight to the result stage.
// Inside the curve it runs a binary search, each step a table read and a compare,
// with up to ceil(log2(n-1)) steps for n points, then walks outward from the
// bracketing pair past unknown values, reading and checking each entry visited
// (at least one on each side), then does the gap check, the multiply-accumulate
// (ST_MUL1, ST_MUL2), the radix-2 divider and the load of the result register,
// which waits while the previous result is unread. Runs of unknown values make
// the walk longer. The divider gives one quotient bit per cycle.
// One request is worked on at a time; a new request is taken while the previous
// result still waits in the output register. Register writes are always ready.
`default_nettype none

module gap_aware_linear_interpolator (
	input  wire logic     clk,
	input  wire logic     arst_n,
	gali_cfg_if.sink      cfg,
	gali_item_if.sink     item,
	gali_result_if.source result
);

	gali_pkg::dp_cmd_t    cmd;
	gali_pkg::dp_status_t status;

	// register writes are always accepted
	assign cfg.ready = 1'b1;

	// sequencing of loads, table search, scans and arithmetic
	gali_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_kind  (item.kind),
		.in_ready (item.ready),
		.cmd      (cmd),
		.status   (status)
	);

	// table memory, search registers, multiply, divide and result register
	gali_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_first_point (item.first_point),
		.in_position    (item.position),
		.in_point_value (item.point_value),
		.in_value_known (item.value_known),
		.cfg_valid      (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.out_value      (result.result_value),
		.out_known      (result.result_known)
	);

endmodule

`default_nettype wire

### tb/tb.sv
// testbench for the gap-aware linear curve interpolator: directed and random requests against a built-in predictor
`timescale 1ns / 100ps

module tb;

	localparam int     CURVE_POINTS  = gali_pkg::CURVE_POINTS;
	localparam int     POS_W         = gali_pkg::POS_W;
	localparam int     VAL_W         = gali_pkg::VAL_W;
	localparam int     RES_W         = gali_pkg::RES_W;
	localparam int     FRAC_W        = gali_pkg::FRAC_W;
	localparam int     GAP_W         = gali_pkg::GAP_W;
	localparam int     CFG_IDX_W     = gali_pkg::CFG_IDX_W;
	localparam int     CFG_DATA_W    = gali_pkg::CFG_DATA_W;
	localparam logic [GAP_W-1:0] MAX_GAP_RESET = gali_pkg::MAX_GAP_RESET;

	localparam int     CLK_PERIOD    = 10;
	localparam int     RESET_CYCLES  = 11;
	// a query is done once its result is out
	localparam int     SETTLE_CYCLES = 8;
	// timeout for the whole run
	localparam longint TIMEOUT_NS    = 64'd30_000_000;
	localparam int     PHASES        = 9;
	localparam int     PHASE_ITEMS   = 100;
	localparam int     LONG_POINTS   = 200;
	// register index with nothing behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'hF;

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic [RES_W-1:0] value;
		logic             known;
	} interp_result_t;

	// curve table model plus the queue of results still owed by the block
	class interp_scoreboard;
		logic [POS_W-1:0] pos_tab [CURVE_POINTS];
		logic [VAL_W-1:0] val_tab [CURVE_POINTS];
		bit               known_tab [CURVE_POINTS];
		int unsigned      n_points;
		logic [GAP_W-1:0] gap_limit;
		bit               hold_flag;
		interp_result_t   owed_q [$];
		int               error_count;

		function new();
			n_points    = 0;
			gap_limit   = MAX_GAP_RESET;
			hold_flag   = 1'b0;
			error_count = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == gali_pkg::REG_MAX_GAP)
				gap_limit = data[GAP_W-1:0];
			else if (idx == gali_pkg::REG_HOLD_ENDS)
				hold_flag = data[0];
		endfunction

		function interp_result_t make_result(u64_t v, bit k);
			interp_result_t r;
			r.value = k ? v[RES_W-1:0] : '0;
			r.known = k;
			return r;
		endfunction

		function interp_result_t interpolate(logic [POS_W-1:0] q);
			int unsigned last, idx, lo, hi, span, d;
			u64_t        num;
			if (n_points == 0)
				return make_result(0, 1'b0);
			last = n_points - 1;
			if (q < pos_tab[0]) begin
				if (hold_flag)
					return make_result(u64_t'(val_tab[0]) << FRAC_W, known_tab[0]);
				return make_result(0, 1'b0);
			end
			if (q >= pos_tab[last]) begin
				if (hold_flag || q == pos_tab[last])
					return make_result(u64_t'(val_tab[last]) << FRAC_W, known_tab[last]);
				return make_result(0, 1'b0);
			end
			idx = 1;
			while (idx < last && pos_tab[idx] <= q)
				idx++;
			lo = idx - 1;
			while (lo > 0 && !known_tab[lo])
				lo--;
			hi = idx;
			while (hi < last && !known_tab[hi])
				hi++;
			if (!known_tab[lo] || !known_tab[hi])
				return make_result(0, 1'b0);
			span = pos_tab[hi] - pos_tab[lo];
			if (span == 0 || span - 1 > gap_limit)
				return make_result(0, 1'b0);
			d   = q - pos_tab[lo];
			num = (u64_t'(val_tab[lo]) * (span - d) + u64_t'(val_tab[hi]) * d) << FRAC_W;
			return make_result((2 * num + span) / (2 * u64_t'(span)), 1'b1);
		endfunction

		// returns 1 when the request changes the table or owes a result
		function bit note_item(gali_pkg::item_kind_t kind, bit first, logic [POS_W-1:0] pos,
				logic [VAL_W-1:0] val, bit known);
			if (kind == gali_pkg::KIND_QUERY) begin
				owed_q.push_back(interpolate(pos));
				return 1'b1;
			end
			if (first)
				n_points = 0;
			else if (n_points >= CURVE_POINTS)
				return 1'b0;
			else if (n_points > 0 && pos <= pos_tab[n_points - 1])
				return 1'b0;
			pos_tab[n_points]   = pos;
			val_tab[n_points]   = val;
			known_tab[n_points] = known;
			n_points++;
			return 1'b1;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			error_count++;
		endtask

		task check_result(logic [RES_W-1:0] value, logic known);
			interp_result_t want;
			if (owed_q.size() == 0) begin
				report($sformatf("result %0h/%0b with no query pending", value, known));
				return;
			end
			want = owed_q.pop_front();
			if (value !== want.value)
				report($sformatf("result_value %0h, expected %0h", value, want.value));
			if (known !== want.known)
				report($sformatf("result_known %0b, expected %0b", known, want.known));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	gali_cfg_if    cfg_ch ();
	gali_item_if   item_ch ();
	gali_result_if res_ch ();

	gap_aware_linear_interpolator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (res_ch)
	);

	interp_scoreboard sb;
	int unsigned      tx_idle_pct;
	int unsigned      rx_idle_pct;
	bit               last_effective;
	int unsigned      effective_items;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// point values lean on the extremes
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// mix of adjacent, close, spread and far-apart curve points
	function automatic int unsigned pick_step();
		case ($urandom_range(9))
			0, 1, 2: return 1;
			3, 4, 5: return $urandom_range(2, 8);
			6, 7, 8: return $urandom_range(9, 300);
			default: return $urandom_range(301, 20000);
		endcase
	endfunction

	// one request on the item channel, with a random gap in front of it
	task automatic send_item(input gali_pkg::item_kind_t kind, input bit first,
			input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val, input bit known);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.kind        <= kind;
		item_ch.first_point <= first;
		item_ch.position    <= pos;
		item_ch.point_value <= val;
		item_ch.value_known <= known;
		do
			@(posedge clk);
		while (item_ch.ready !== 1'b1);
		last_effective = sb.note_item(kind, first, pos, val, known);
		if (last_effective)
			effective_items++;
	endtask

	// sender holds off until every owed result is out and the block is quiet
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// leaves valid high; the caller lowers it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(input logic [GAP_W-1:0] gap, input bit hold, input bit poke_spare);
		write_reg(gali_pkg::REG_MAX_GAP, gap);
		write_reg(gali_pkg::REG_HOLD_ENDS, {{(CFG_DATA_W-1){1'b0}}, hold});
		if (poke_spare)
			write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	// fresh curve with random content, then queries around and inside it
	task automatic curve_sequence();
		logic [POS_W-1:0] placed [$];
		logic [POS_W-1:0] lo_p, hi_p, q;
		int unsigned      n_pts, cur, unknown_run, i;
		bit               known, first;
		n_pts       = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 20);
		cur         = ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 400);
		unknown_run = 0;
		for (i = 0; i < n_pts && cur <= 65535; i++) begin
			// short runs of missing values for the outward walk
			if (unknown_run > 0) begin
				known = 1'b0;
				unknown_run--;
			end else if ($urandom_range(6) == 0) begin
				known       = 1'b0;
				unknown_run = $urandom_range(0, 3);
			end else begin
				known = 1'b1;
			end
			// a stale position now and then, which the table must drop
			if (placed.size() != 0 && $urandom_range(11) == 0)
				send_item(gali_pkg::KIND_LOAD, 1'b0, POS_W'($urandom_range(0, placed[$])),
					pick_value(), 1'($urandom_range(1)));
			// a broken start now and then appends to the previous curve
			first = (i == 0) ? ($urandom_range(9) != 0) : 1'b0;
			send_item(gali_pkg::KIND_LOAD, first, POS_W'(cur), pick_value(), known);
			if (last_effective)
				placed.push_back(POS_W'(cur));
			cur += pick_step();
		end
		if (placed.size() == 0)
			return;
		lo_p = placed[0];
		hi_p = placed[$];
		repeat ($urandom_range(2, 8)) begin
			case ($urandom_range(7))
				0: q = placed[$urandom_range(0, placed.size() - 1)];
				1: q = POS_W'($urandom_range(0, lo_p));
				2: q = POS_W'($urandom_range(hi_p, 65535));
				3: q = hi_p;
				7: q = POS_W'($urandom);
				default: q = POS_W'($urandom_range(lo_p, hi_p));
			endcase
			send_item(gali_pkg::KIND_QUERY, 1'($urandom_range(1)), q, pick_value(),
				1'($urandom_range(1)));
		end
	endtask

	// result side: check what was taken at this edge, then pick the next ready
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
				sb.check_result(res_ch.result_value, res_ch.result_known);
			res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int unsigned      phase, i, start;
		logic [GAP_W-1:0] gap;
		sb              = new();
		effective_items = 0;
		last_effective  = 1'b0;
		// sender idles less, receiver stalls more
		tx_idle_pct     = 23;
		rx_idle_pct     = 54;
		arst_n              <= 1'b0;
		item_ch.valid       <= 1'b0;
		item_ch.kind        <= gali_pkg::KIND_LOAD;
		item_ch.first_point <= 1'b0;
		item_ch.position    <= '0;
		item_ch.point_value <= '0;
		item_ch.value_known <= 1'b0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= gali_pkg::REG_MAX_GAP;
		cfg_ch.data         <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings: no gap limit, ends give missing
		// query on an empty table
		send_item(gali_pkg::KIND_QUERY, 1'b1, 16'd1000, '1, 1'b1);
		send_item(gali_pkg::KIND_LOAD, 1'b1, 16'd100, 16'd0, 1'b1);
		send_item(gali_pkg::KIND_LOAD, 1'b0, 16'd200, 16'hFFFF, 1'b1);
		// equal and lower positions are dropped
		send_item(gali_pkg::KIND_LOAD, 1'b0, 16'd200, 16'd7, 1'b1);
		send_item(gali_pkg::KIND_LOAD, 1'b0, 16'd150, 16'd7, 1'b1);
		send_item(gali_pkg::KIND_LOAD, 1'b0, 16'd300, 16'd1234, 1'b0);
		send_item(gali_pkg::KIND_LOAD, 1'b0, 16'd400, 16'd3, 1'b1);
		send_item(gali_pkg::KIND_LOAD, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1);
		// below first, at first, inside, across the missing point, at and near last
		send_item(gali_pkg::KIND_QUERY, 1'b0, 16'd50, 16'h5A5A, 1'b0);
		send_item(gali_pkg::KIND_QUERY, 1'b0, 16'd100, '0, 1'b1);
		send_item(gali_pkg::KIND_QUERY, 1'b1, 16'd150, '1, 1'b0);
		send_item(gali_pkg::KIND_QUERY, 1'b0, 16'd201, 16'hA5A5, 1'b1);
		send_item(gali_pkg::KIND_QUERY, 1'b0, 16'd250, '0, 1'b0);
		send_item(gali_pkg::KIND_QUERY, 1'b0, 16'hFFFF, '1, 1'b1);
		send_item(gali_pkg::KIND_QUERY, 1'b0, 16'hFFFE, '0, 1'b0);
		// second curve: missing first and last values, a rounding tie
		send_item(gali_pkg::KIND_LOAD, 1'b1, 16'd0, 16'hFFFF, 1'b0);
		send_item(gali_pkg::KIND_LOAD, 1'b0, 16'd1, 16'd0, 1'b1);
		send_item(gali_pkg::KIND_LOAD, 1'b0, 16'd513, 16'd1, 1'b1);
		send_item(gali_pkg::KIND_LOAD, 1'b0, 16'd515, 16'hFFFF, 1'b1);
		send_item(gali_pkg::KIND_LOAD, 1'b0, 16'hFFFF, 16'd0, 1'b0);
		// half an lsb rounds up
		send_item(gali_pkg::KIND_QUERY, 1'b0, 16'd2, '0, 1'b0);
		send_item(gali_pkg::KIND_QUERY, 1'b0, 16'd514, '0, 1'b0);
		// right walk stops at the last entry, which is missing
		send_item(gali_pkg::KIND_QUERY, 1'b0, 16'd600, '0, 1'b0);
		send_item(gali_pkg::KIND_QUERY, 1'b0, 16'd0, '0, 1'b0);
		send_item(gali_pkg::KIND_QUERY, 1'b0, 16'hFFFF, '0, 1'b0);

		// long curve with one missing run, then points far past it
		wait_idle();
		configure(MAX_GAP_RESET, 1'b1, 1'b0);
		for (i = 0; i < LONG_POINTS; i++)
			send_item(gali_pkg::KIND_LOAD, i == 0, POS_W'(i * 4), pick_value(),
				!(i >= 120 && i < 133) && $urandom_range(19) != 0);
		send_item(gali_pkg::KIND_LOAD, 1'b0, 16'hFFFD, pick_value(), 1'b1);
		send_item(gali_pkg::KIND_LOAD, 1'b0, 16'hFFFF, pick_value(), 1'b1);
		send_item(gali_pkg::KIND_QUERY, 1'b0, 16'hFFFC, '0, 1'b0);
		send_item(gali_pkg::KIND_QUERY, 1'b0, 16'hFFFF, '0, 1'b0);
		send_item(gali_pkg::KIND_QUERY, 1'b0, 16'd501, '0, 1'b0);
		repeat (12)
			send_item(gali_pkg::KIND_QUERY, 1'b0, POS_W'($urandom_range(0, 820)), '0, 1'b0);

		// random part: register settings change between phases, idling per third
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase / 3)
				0: begin
					tx_idle_pct = 23;
					rx_idle_pct = 54;
				end
				1: begin
					tx_idle_pct = 54;
					rx_idle_pct = 23;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			case (phase)
				0, 3:    gap = MAX_GAP_RESET;
				1, 6:    gap = '0;
				4:       gap = GAP_W'(2);
				2, 7:    gap = GAP_W'($urandom_range(1, 64));
				default: gap = GAP_W'($urandom);
			endcase
			configure(gap, 1'(phase % 2), $urandom_range(2) == 0);
			start = effective_items;
			while (effective_items - start < PHASE_ITEMS) begin
				if ($urandom_range(6) != 0)
					curve_sequence();
				else
					send_item(gali_pkg::item_kind_t'($urandom_range(1)),
						1'($urandom_range(1)), POS_W'($urandom), pick_value(),
						1'($urandom_range(1)));
			end
		end

		// drain and let the block settle
		wait_idle();
		repeat (64) @(posedge clk);
		if (sb.error_count == 0 && sb.owed_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### gap_aware_linear_interpolator.f
hdl/gali_pkg.sv
hdl/gali_if.sv
hdl/gali_ctrl.sv
hdl/gali_dp.sv
hdl/gap_aware_linear_interpolator.sv
tb/tb.sv
